// File: sv/lkv_pkg.sv
// Shared types and constants for the LRU key-value store.
// Used by the controller, the datapath and the top level; depends on nothing.
package lkv_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int CAP_W        = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

// File: sv/lkv_ram.sv
// Generic single-port RAM with a registered read.
// Holds the stored values of the LRU key-value store; depends on nothing.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: sv/lkv_ctrl.sv
// Controller of the LRU key-value store: accept, execute and output handshake.
// Depends on lkv_pkg for the command struct.
module lkv_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lkv_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE = 2'b01,
    EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd.capture    = (state == IDLE) && in_valid;
    cmd.execute    = (state == EXEC) && out_free;
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end
    unique case (state)
      IDLE: begin
        if (cmd.capture) begin
          state_next = EXEC;
        end
      end
      EXEC: begin
        if (cmd.execute) begin
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: sv/lkv_datapath.sv
// Datapath of the LRU key-value store: key and rank cells, fill count, capacity
// register and result registers. Depends on lkv_pkg and instantiates lkv_ram.
module lkv_datapath #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lkv_pkg::cmd_t                 cmd,
  input  logic                          cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]     cfg_wr_data,
  input  logic                          in_func,
  input  logic [31:0]                   in_key,
  input  logic [lkv_pkg::DATA_W-1:0]    in_value,
  output logic                          out_hit,
  output logic [lkv_pkg::DATA_W-1:0]    out_read_value,
  output logic                          out_evicted,
  output logic [31:0]                   out_evicted_key
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);

  logic                          op_func;
  logic [KEY_BITS-1:0]           op_key;
  logic [lkv_pkg::DATA_W-1:0]    op_value;
  logic [lkv_pkg::CAP_W-1:0]     capacity;

  logic [ENTRIES-1:0]            valid;
  logic [KEY_BITS-1:0]           ekey [ENTRIES];
  logic [IW-1:0]                 rank [ENTRIES];
  logic [UW-1:0]                 used_count;

  logic                          res_get_hit;
  logic [lkv_pkg::DATA_W-1:0]    ram_rdata;

  logic [63:0]                   key_wide;
  logic [63:0]                   evk_wide;
  logic [ENTRIES-1:0]            match;
  logic [ENTRIES-1:0]            oldest;
  logic                          hit;
  logic [IW-1:0]                 hit_idx;
  logic [IW-1:0]                 hit_rank;
  logic [IW-1:0]                 evict_idx;
  logic [KEY_BITS-1:0]           evict_key;
  logic [IW-1:0]                 free_idx;
  logic [UW-1:0]                 cap_eff;
  logic [IW-1:0]                 last_rank;
  logic                          full;
  logic [IW-1:0]                 slot;
  logic                          ram_en;
  logic                          ram_we;
  logic [IW-1:0]                 ram_addr;

  assign key_wide = 64'(in_key);

  always_comb begin
    match     = '0;
    oldest    = '0;
    hit_idx   = '0;
    hit_rank  = '0;
    evict_idx = '0;
    evict_key = '0;
    free_idx  = '0;
    if (capacity == '0) begin
      cap_eff = UW'(1);
    end else if (32'(capacity) > ENTRIES) begin
      cap_eff = UW'(ENTRIES);
    end else begin
      cap_eff = UW'(capacity);
    end
    full      = (used_count >= cap_eff);
    last_rank = IW'(used_count - UW'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (ekey[i] == op_key);
      oldest[i] = valid[i] && (rank[i] == last_rank);
      hit_idx   = hit_idx | (match[i] ? IW'(i) : '0);
      hit_rank  = hit_rank | (match[i] ? rank[i] : '0);
      evict_idx = evict_idx | (oldest[i] ? IW'(i) : '0);
      evict_key = evict_key | (oldest[i] ? ekey[i] : '0);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
    end
    hit      = |match;
    slot     = full ? evict_idx : free_idx;
    evk_wide = 64'(evict_key);
    ram_en   = cmd.execute && (hit || (op_func == lkv_pkg::FUNC_PUT));
    ram_we   = (op_func == lkv_pkg::FUNC_PUT);
    ram_addr = hit ? hit_idx : slot;
  end

  lkv_ram #(
    .WIDTH (lkv_pkg::DATA_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (op_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_func  <= in_func;
      op_key   <= key_wide[KEY_BITS-1:0];
      op_value <= in_value;
    end
    if (cmd.execute) begin
      out_hit         <= hit;
      res_get_hit     <= hit && (op_func == lkv_pkg::FUNC_GET);
      out_evicted     <= !hit && (op_func == lkv_pkg::FUNC_PUT) && full;
      out_evicted_key <= (!hit && (op_func == lkv_pkg::FUNC_PUT) && full) ?
                         evk_wide[31:0] : '0;
    end
  end

  // Key and rank cells. A hit moves the entry to rank zero and ages the
  // younger ones; an insert ages every other valid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      used_count <= '0;
      capacity   <= lkv_pkg::CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (cmd.execute) begin
        if (hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
              rank[i] <= '0;
            end else if (valid[i] && (rank[i] < hit_rank)) begin
              rank[i] <= IW'(rank[i] + IW'(1));
            end
          end
        end else if (op_func == lkv_pkg::FUNC_PUT) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (IW'(i) == slot) begin
              valid[i] <= 1'b1;
              ekey[i]  <= op_key;
              rank[i]  <= '0;
            end else if (valid[i]) begin
              rank[i] <= IW'(rank[i] + IW'(1));
            end
          end
          if (!full) begin
            used_count <= UW'(used_count + UW'(1));
          end
        end
      end
    end
  end

  assign out_read_value = res_get_hit ? ram_rdata : '0;

endmodule

// File: sv/lru_key_value_store_top.sv
// LRU key-value store, top level. An item is captured when it is accepted; then a
// compare and update pass compares all keys in parallel and updates the ranks, the
// cells and the value RAM, and registers the result for the output.
// The controller alternates between capture and that pass, so a new item is not
// accepted until the last one has been through it; a waiting result holds back the pass.
// Reset empties the store and sets the capacity to 16; there is no clearing pass.
module lru_key_value_store_top #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data,   // capacity_in_use
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // key [31:0], put_value [63:32]
  input  logic [0:0]                s_axis_tuser,  // func [0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [63:0]               m_axis_tdata,  // read_value [31:0], evicted_key [63:32]
  output logic [1:0]                m_axis_tuser   // hit [0], evicted [1]
);

  lkv_pkg::cmd_t               cmd;
  logic                        res_hit;
  logic                        res_evicted;
  logic [lkv_pkg::DATA_W-1:0]  res_read_value;
  logic [31:0]                 res_evicted_key;

  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  lkv_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_func         (s_axis_tuser[0]),
    .in_key          (s_axis_tdata[31:0]),
    .in_value        (s_axis_tdata[63:32]),
    .out_hit         (res_hit),
    .out_read_value  (res_read_value),
    .out_evicted     (res_evicted),
    .out_evicted_key (res_evicted_key)
  );

  assign m_axis_tdata = {res_evicted_key, res_read_value};
  assign m_axis_tuser = {res_evicted, res_hit};

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for lru_key_value_store_top: a queue-fed stream driver, a monitor and
// an in-bench LRU predictor that holds its own copy of the entries and the capacity.
// Depends on lkv_pkg and the RTL of the store only.
module testbench;

  localparam int NSLOTS = lkv_pkg::ENTRIES_DEF;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic                       func;
    logic [31:0]                key;
    logic [lkv_pkg::DATA_W-1:0] value;
  } lru_op_t;

  typedef struct packed {
    logic                       hit;
    logic [lkv_pkg::DATA_W-1:0] read_value;
    logic                       evicted;
    logic [31:0]                evicted_key;
  } lru_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr_en = 1'b0;
  logic [lkv_pkg::CAP_W-1:0] cfg_wr_data = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [63:0]               s_axis_tdata = '0;
  logic [0:0]                s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [63:0]               m_axis_tdata;
  logic [1:0]                m_axis_tuser;

  lru_key_value_store_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Predictor state.
  logic                       slot_valid [NSLOTS];
  logic [31:0]                slot_key   [NSLOTS];
  logic [lkv_pkg::DATA_W-1:0] slot_value [NSLOTS];
  logic [3:0]                 slot_rank  [NSLOTS];
  logic [4:0]                 slot_fill;
  logic [lkv_pkg::CAP_W-1:0]  cap_setting;

  lru_op_t     pending_ops[$];
  lru_result_t expected_results[$];
  int          ops_queued = 0;
  int          ops_accepted = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        in_fire = 1'b0;
  int          src_gap_odds = 0;
  int          sink_gap_odds = 0;
  int          src_idle_left = 0;
  int          sink_stall_left = 0;

  function automatic int eff_capacity(logic [lkv_pkg::CAP_W-1:0] c);
    if (c < 1) return 1;
    if (c > NSLOTS) return NSLOTS;
    return int'(c);
  endfunction

  function automatic lru_result_t lru_apply(lru_op_t op);
    lru_result_t r;
    int          hit_slot;
    int          slot;
    logic [3:0]  old_rank;
    logic [3:0]  oldest;
    r = '0;
    hit_slot = -1;
    slot = -1;
    oldest = '0;
    for (int i = 0; i < NSLOTS; i++)
      if (slot_valid[i] && slot_key[i] == op.key) hit_slot = i;
    if (hit_slot >= 0) begin
      r.hit = 1'b1;
      if (op.func == lkv_pkg::FUNC_GET) r.read_value = slot_value[hit_slot];
      else slot_value[hit_slot] = op.value;
      old_rank = slot_rank[hit_slot];
      for (int i = 0; i < NSLOTS; i++)
        if (slot_valid[i] && i != hit_slot && slot_rank[i] < old_rank) slot_rank[i]++;
      slot_rank[hit_slot] = '0;
    end else if (op.func == lkv_pkg::FUNC_PUT) begin
      if (slot_fill >= eff_capacity(cap_setting)) begin
        for (int i = 0; i < NSLOTS; i++)
          if (slot_valid[i] && (slot < 0 || slot_rank[i] > oldest)) begin
            slot = i;
            oldest = slot_rank[i];
          end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[slot];
          slot_valid[slot] = 1'b0;
          slot_fill--;
        end
      end
      if (slot < 0)
        for (int i = NSLOTS - 1; i >= 0; i--)
          if (!slot_valid[i]) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < NSLOTS; i++)
          if (slot_valid[i]) slot_rank[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot] = op.key;
        slot_value[slot] = op.value;
        slot_rank[slot] = '0;
        slot_fill++;
      end
    end
    return r;
  endfunction

  task automatic queue_op(logic func, logic [31:0] key, logic [lkv_pkg::DATA_W-1:0] value);
    lru_op_t op;
    op.func = func;
    op.key = key;
    op.value = value;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  task automatic drain_store();
    while (ops_accepted != ops_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [lkv_pkg::CAP_W-1:0] c);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    cap_setting = c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= lkv_pkg::CAP_W'($urandom);
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL lru_key_value_store_top");
      $finish;
    end
  end

  // Source side: holds an item until it is taken, with random idle bursts between items.
  always @(negedge clk) begin : src_drv
    lru_op_t op;
    logic    next_valid;
    if (!rst && !(s_axis_tvalid && !in_fire)) begin
      next_valid = 1'b0;
      if (src_idle_left > 0) begin
        src_idle_left--;
      end else if (src_gap_odds != 0 && $urandom_range(0, src_gap_odds) == 0) begin
        src_idle_left = $urandom_range(0, 16);
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        next_valid = 1'b1;
        s_axis_tdata <= {op.value, op.key};
        s_axis_tuser <= op.func;
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Sink side: random stall bursts on tready.
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_stall_left > 0) begin
        sink_stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_gap_odds != 0 && $urandom_range(0, sink_gap_odds) == 0) begin
        sink_stall_left = $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    lru_op_t     op;
    lru_result_t want;
    lru_result_t got;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) begin
        op = {s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[63:32]};
        expected_results.push_back(lru_apply(op));
        ops_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tuser[1], m_axis_tdata[63:32]};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result item: hit=%0b read=%h evicted=%0b evicted_key=%h",
                     got.hit, got.read_value, got.evicted, got.evicted_key);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"Mismatch: expected hit=%0b read=%h evicted=%0b evicted_key=%h, ",
                        "got hit=%0b read=%h evicted=%0b evicted_key=%h"},
                       want.hit, want.read_value, want.evicted, want.evicted_key,
                       got.hit, got.read_value, got.evicted, got.evicted_key);
          end
        end
      end
    end
  end

  initial begin
    logic [lkv_pkg::CAP_W-1:0] phase_caps [10];
    logic [31:0]               key_pool [24];
    logic [31:0]               k;
    int                        pool_n;
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'd9, 5'd3, 5'd2, 5'd16};
    for (int i = 0; i < NSLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_rank[i] = '0;
    end
    slot_fill = '0;
    cap_setting = lkv_pkg::CAP_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_capacity(lkv_pkg::CAP_RESET);

    // Inserts, hits, a miss and an update at the key and value extremes.
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_op(lkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h5555_5555);
    queue_op(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(lkv_pkg::FUNC_GET, 32'h1234_5678, 32'hAAAA_AAAA);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0011);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0002, 32'h0000_0022);
    drain_store();

    // Capacity lowered below the fill: each new key evicts one entry.
    write_capacity(5'd2);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0003, 32'h0000_0033);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0004, 32'h0000_0044);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0001, 32'h0000_0099);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0003, 32'hFFFF_FFFF);
    drain_store();

    // A capacity of zero acts as one.
    write_capacity(5'd0);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0005, 32'h0000_0055);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0002, 32'h0000_0000);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0005, 32'h0000_0000);
    drain_store();

    // A capacity above the entry count acts as the entry count.
    write_capacity(5'd31);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0006, 32'h0000_0066);
    queue_op(lkv_pkg::FUNC_PUT, 32'h0000_0007, 32'h0000_0077);
    queue_op(lkv_pkg::FUNC_GET, 32'h0000_0004, 32'h0000_0000);
    drain_store();

    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      if (p == 9) begin
        src_gap_odds = 0;
        sink_gap_odds = 0;
      end else begin
        src_gap_odds = $urandom_range(0, 3) * 4;
        sink_gap_odds = $urandom_range(0, 3) * 4;
      end
      pool_n = eff_capacity(phase_caps[p]) + $urandom_range(0, 6);
      for (int j = 0; j < pool_n; j++) key_pool[j] = $urandom;
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        queue_op($urandom_range(0, 1) ? lkv_pkg::FUNC_GET : lkv_pkg::FUNC_PUT, k, $urandom);
      end
      drain_store();
    end

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS lru_key_value_store_top");
    end else begin
      $display("FAIL lru_key_value_store_top");
    end
    $finish;
  end

endmodule

// File: lru_key_value_store_top.f
sv/lkv_pkg.sv
sv/lkv_ram.sv
sv/lkv_ctrl.sv
sv/lkv_datapath.sv
sv/lru_key_value_store_top.sv
test/testbench.sv
